>>> hdl/fht_pkg.sv
`default_nettype none

package fht_pkg;

   localparam int MAX_FRAGS_DEF = 32;

   localparam int OFF_W  = 16;
   localparam int LEN_W  = 16;
   localparam int TOT_W  = 17;
   localparam int HOLE_W = 9;
   localparam int FCNT_W = 9;
   localparam int STAT_W = 3;

   localparam logic OP_ADD     = 1'b0;
   localparam logic OP_ABANDON = 1'b1;

   localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd0;
   localparam logic [STAT_W-1:0] ST_COMPLETE = 3'd1;
   localparam logic [STAT_W-1:0] ST_REJECTED = 3'd2;
   localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd3;
   localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd4;

   typedef struct packed {
      logic load;
      logic idx_clear;
      logic idx_load_count;
      logic scan_rd;
      logic scan_eval;
      logic shift_rd;
      logic shift_wr;
      logic commit;
      logic drop;
      logic abandon;
   } cmd_type;

   typedef struct packed {
      logic is_abandon;
      logic invalid;
      logic scan_more;
      logic found;
      logic store;
      logic shift_more;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

>>> hdl/fht_ctrl.sv
`default_nettype none

module fht_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fht_pkg::stat_type stat,
   output fht_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      IDLE,
      DISPATCH,
      SCAN,
      DECIDE,
      SHIFT,
      COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      pend_in   = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = DISPATCH;
            end
         end
         DISPATCH: begin
            if (stat.is_abandon) begin
               if (stat.out_free) begin
                  cmd.abandon = 1'b1;
                  state_in    = IDLE;
               end
            end else if (stat.invalid) begin
               if (stat.out_free) begin
                  cmd.drop = 1'b1;
                  state_in = IDLE;
               end
            end else begin
               cmd.idx_clear = 1'b1;
               state_in      = SCAN;
            end
         end
         SCAN: begin
            cmd.scan_rd   = stat.scan_more && !stat.found;
            cmd.scan_eval = pend_ff;
            pend_in       = cmd.scan_rd;
            if (!pend_ff && !cmd.scan_rd) begin
               state_in = DECIDE;
            end
         end
         DECIDE: begin
            if (stat.store) begin
               cmd.idx_load_count = 1'b1;
               state_in           = SHIFT;
            end else begin
               state_in = COMMIT;
            end
         end
         SHIFT: begin
            cmd.shift_rd = stat.shift_more;
            cmd.shift_wr = pend_ff;
            pend_in      = cmd.shift_rd;
            if (!pend_ff && !stat.shift_more) begin
               state_in = COMMIT;
            end
         end
         COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/fht_datapath.sv
`default_nettype none

module fht_datapath #(
   parameter int MAX_FRAGS = fht_pkg::MAX_FRAGS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fht_pkg::cmd_type             cmd,
   output fht_pkg::stat_type                 stat,
   input  wire logic                         req_operation,
   input  wire logic [fht_pkg::OFF_W-1:0]    req_frag_offset,
   input  wire logic [fht_pkg::LEN_W-1:0]    req_frag_length,
   input  wire logic                         req_is_last,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [fht_pkg::STAT_W-1:0]        rsp_status,
   output logic [fht_pkg::TOT_W-1:0]         rsp_total_length,
   output logic [fht_pkg::HOLE_W-1:0]        rsp_hole_count,
   output logic [fht_pkg::FCNT_W-1:0]        rsp_fragment_count,
   output logic [fht_pkg::FCNT_W-1:0]        rsp_fragments_dropped
);

   localparam int IDX_W = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
   localparam int CNT_W = $clog2(MAX_FRAGS + 1);
   localparam int OFF_W = fht_pkg::OFF_W;
   localparam int LEN_W = fht_pkg::LEN_W;
   localparam int TOT_W = fht_pkg::TOT_W;
   localparam int HOLE_W = fht_pkg::HOLE_W;
   localparam int FCNT_W = fht_pkg::FCNT_W;

   logic [OFF_W-1:0] mem_start [MAX_FRAGS];
   logic [LEN_W-1:0] mem_len   [MAX_FRAGS];

   // item
   logic             op_ff;
   logic [OFF_W-1:0] off_ff;
   logic [LEN_W-1:0] len_ff;
   logic             last_ff;

   // tracker state
   logic [TOT_W-1:0]  dlen_ff;
   logic [HOLE_W-1:0] gaps_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              invalid_ff;

   // walk
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] rd_addr_in, rd_addr_ff;
   logic [OFF_W-1:0] rd_start_ff;
   logic [LEN_W-1:0] rd_len_ff;
   logic [CNT_W-1:0] pos_ff;
   logic [TOT_W-1:0] prev_end_ff;
   logic [OFF_W-1:0] next_ff;
   logic             found_ff;

   // result
   logic              rsp_valid_ff;
   logic [fht_pkg::STAT_W-1:0] rsp_status_ff;
   logic [TOT_W-1:0]  rsp_total_ff;
   logic [HOLE_W-1:0] rsp_holes_ff;
   logic [FCNT_W-1:0] rsp_count_ff;
   logic [FCNT_W-1:0] rsp_dropped_ff;

   logic [TOT_W-1:0]  end_w;
   logic              touch_prev;
   logic              touch_next;
   logic              reject;
   logic              store;
   logic [TOT_W-1:0]  dlen_new;
   logic [HOLE_W-1:0] gaps_new;
   logic [CNT_W-1:0]  count_new;

   always_comb begin
      end_w      = {1'b0, off_ff} + {1'b0, len_ff};
      touch_prev = (prev_end_ff == {1'b0, off_ff});
      touch_next = last_ff || (found_ff && (end_w == {1'b0, next_ff}));
      reject     = (!last_ff && (len_ff[2:0] != 3'd0))
                || ((dlen_ff != '0) && (end_w > dlen_ff))
                || (last_ff && (dlen_ff != '0))
                || (prev_end_ff > {1'b0, off_ff})
                || (found_ff && last_ff)
                || (found_ff && (end_w > {1'b0, next_ff}))
                || ((len_ff != '0) && (count_ff >= CNT_W'(MAX_FRAGS)));
      store      = !reject && (len_ff != '0);
      dlen_new   = last_ff ? end_w : dlen_ff;
      count_new  = store ? count_ff + CNT_W'(1) : count_ff;
      gaps_new   = gaps_ff;
      if (len_ff != '0) begin
         if (touch_prev && touch_next) begin
            gaps_new = gaps_ff - HOLE_W'(1);
         end else if (!touch_prev && !touch_next) begin
            gaps_new = gaps_ff + HOLE_W'(1);
         end
      end else if (last_ff && touch_prev) begin
         gaps_new = gaps_ff - HOLE_W'(1);
      end
   end

   always_comb begin
      stat.is_abandon = (op_ff == fht_pkg::OP_ABANDON);
      stat.invalid    = invalid_ff;
      stat.scan_more  = (idx_ff < count_ff);
      stat.found      = found_ff;
      stat.store      = store;
      stat.shift_more = (idx_ff > pos_ff);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      idx_in     = idx_ff;
      rd_addr_in = IDX_W'(idx_ff);
      priority if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_load_count) begin
         idx_in = count_ff;
      end else if (cmd.scan_rd) begin
         idx_in = idx_ff + CNT_W'(1);
      end else if (cmd.shift_rd) begin
         rd_addr_in = IDX_W'(idx_ff - CNT_W'(1));
         idx_in     = idx_ff - CNT_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   // extent memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.commit && store) begin
         mem_start[IDX_W'(pos_ff)] <= off_ff;
         mem_len[IDX_W'(pos_ff)]   <= len_ff;
      end else if (cmd.shift_wr) begin
         mem_start[rd_addr_ff + IDX_W'(1)] <= rd_start_ff;
         mem_len[rd_addr_ff + IDX_W'(1)]   <= rd_len_ff;
      end
      if (cmd.scan_rd || cmd.shift_rd) begin
         rd_start_ff <= mem_start[rd_addr_in];
         rd_len_ff   <= mem_len[rd_addr_in];
         rd_addr_ff  <= rd_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         op_ff   <= req_operation;
         off_ff  <= req_frag_offset;
         len_ff  <= req_frag_length;
         last_ff <= req_is_last;
      end
      if (cmd.idx_clear) begin
         pos_ff      <= '0;
         prev_end_ff <= '0;
         found_ff    <= 1'b0;
      end else if (cmd.scan_eval && !found_ff) begin
         if (rd_start_ff <= off_ff) begin
            prev_end_ff <= {1'b0, rd_start_ff} + {1'b0, rd_len_ff};
            pos_ff      <= CNT_W'(rd_addr_ff) + CNT_W'(1);
         end else begin
            found_ff <= 1'b1;
            next_ff  <= rd_start_ff;
         end
      end
      if (cmd.abandon) begin
         rsp_status_ff  <= fht_pkg::ST_CLEARED;
         rsp_total_ff   <= '0;
         rsp_holes_ff   <= HOLE_W'(1);
         rsp_count_ff   <= '0;
         rsp_dropped_ff <= '0;
      end else if (cmd.drop) begin
         rsp_status_ff  <= fht_pkg::ST_DROPPED;
         rsp_total_ff   <= dlen_ff;
         rsp_holes_ff   <= gaps_ff;
         rsp_count_ff   <= FCNT_W'(count_ff);
         rsp_dropped_ff <= FCNT_W'(1);
      end else if (cmd.commit) begin
         if (reject) begin
            rsp_status_ff  <= fht_pkg::ST_REJECTED;
            rsp_total_ff   <= dlen_ff;
            rsp_holes_ff   <= gaps_ff;
            rsp_count_ff   <= FCNT_W'(count_ff);
            rsp_dropped_ff <= FCNT_W'(count_ff) + FCNT_W'(1);
         end else begin
            rsp_status_ff  <= (gaps_new == '0) ? fht_pkg::ST_COMPLETE
                                                : fht_pkg::ST_ACCEPTED;
            rsp_total_ff   <= dlen_new;
            rsp_holes_ff   <= gaps_new;
            rsp_count_ff   <= FCNT_W'(count_new);
            rsp_dropped_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dlen_ff      <= '0;
         gaps_ff      <= HOLE_W'(1);
         count_ff     <= '0;
         invalid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.abandon || (cmd.commit && !reject && (gaps_new == '0))) begin
            dlen_ff    <= '0;
            gaps_ff    <= HOLE_W'(1);
            count_ff   <= '0;
            invalid_ff <= 1'b0;
         end else if (cmd.commit && reject) begin
            invalid_ff <= 1'b1;
         end else if (cmd.commit) begin
            dlen_ff  <= dlen_new;
            gaps_ff  <= gaps_new;
            count_ff <= count_new;
         end
         if (cmd.abandon || cmd.drop || cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_total_length      = rsp_total_ff;
   assign rsp_hole_count        = rsp_holes_ff;
   assign rsp_fragment_count    = rsp_count_ff;
   assign rsp_fragments_dropped = rsp_dropped_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAGS))
      else $error("stored count beyond capacity");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && store) |-> (count_ff < CNT_W'(MAX_FRAGS)))
      else $error("insert into a full list");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && cmd.shift_wr))
      else $error("shift and insert in one cycle");

   a_complete_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !reject && (gaps_new == '0))
      |=> (count_ff == '0) && (gaps_ff == HOLE_W'(1)) && !invalid_ff)
      else $error("tracker not cleared after completion");

   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit || cmd.drop || cmd.abandon) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

endmodule

`default_nettype wire

>>> hdl/fragment_hole_tracker_top.sv
// flow: abandon and dropped items register their result in DISPATCH once the result slot
//   is free; an add item walks the stored extents in SCAN, passes DECIDE, shifts later
//   extents in SHIFT if stored, and registers its result in COMMIT once the slot is free
// throughput: one item at a time; the next item is accepted the cycle after the result is
//   registered, while that result may still wait on rsp_ready
// reset: clears flags, result valid, length, count; holes to 1; extent memory not cleared
`default_nettype none

module fragment_hole_tracker_top #(
   parameter int MAX_FRAGS = fht_pkg::MAX_FRAGS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_operation,
   input  wire logic [fht_pkg::OFF_W-1:0]    req_frag_offset,
   input  wire logic [fht_pkg::LEN_W-1:0]    req_frag_length,
   input  wire logic                         req_is_last,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [fht_pkg::STAT_W-1:0]        rsp_status,
   output logic [fht_pkg::TOT_W-1:0]         rsp_total_length,
   output logic [fht_pkg::HOLE_W-1:0]        rsp_hole_count,
   output logic [fht_pkg::FCNT_W-1:0]        rsp_fragment_count,
   output logic [fht_pkg::FCNT_W-1:0]        rsp_fragments_dropped
);

   fht_pkg::cmd_type  cmd;
   fht_pkg::stat_type stat;

   fht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fht_datapath #(
      .MAX_FRAGS (MAX_FRAGS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_operation         (req_operation),
      .req_frag_offset       (req_frag_offset),
      .req_frag_length       (req_frag_length),
      .req_is_last           (req_is_last),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_total_length      (rsp_total_length),
      .rsp_hole_count        (rsp_hole_count),
      .rsp_fragment_count    (rsp_fragment_count),
      .rsp_fragments_dropped (rsp_fragments_dropped)
   );

endmodule

`default_nettype wire

>>> dv/tb_fragment_hole_tracker_top.sv
`timescale 1ns / 100ps

module tb_fragment_hole_tracker_top;

   localparam int MAX_FRAGS     = fht_pkg::MAX_FRAGS_DEF;
   localparam int OFF_W         = fht_pkg::OFF_W;
   localparam int LEN_W         = fht_pkg::LEN_W;
   localparam int TOT_W         = fht_pkg::TOT_W;
   localparam int HOLE_W        = fht_pkg::HOLE_W;
   localparam int FCNT_W        = fht_pkg::FCNT_W;
   localparam int STAT_W        = fht_pkg::STAT_W;
   localparam int RANDOM_ITEMS  = 420;
   localparam int DRAIN_AT      = 250;
   localparam int HOLD_START    = 3000;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 100;
   localparam int TIMEOUT_NS    = 5_000_000;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TOT_W-1:0]  total_length;
      logic [HOLE_W-1:0] hole_count;
      logic [FCNT_W-1:0] fragment_count;
      logic [FCNT_W-1:0] fragments_dropped;
   } frag_result_type;

   typedef struct packed {
      logic             op;
      logic [OFF_W-1:0] off;
      logic [LEN_W-1:0] len;
      logic             last;
      logic             typed;
      frag_result_type  exp;
   } dir_row_type;

   localparam int DIR_ROWS = 26;
   localparam dir_row_type DIRECTED_ROWS [0:DIR_ROWS-1] = '{
      '{fht_pkg::OP_ABANDON, 16'd0, 16'd0, 1'b0, 1'b1,
        '{fht_pkg::ST_CLEARED, 17'd0, 9'd1, 9'd0, 9'd0}},
      '{fht_pkg::OP_ADD, 16'd0, 16'd8, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd16, 16'd8, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd8, 16'd8, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd24, 16'd5, 1'b1, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd0, 16'd7, 1'b0, 1'b1,
        '{fht_pkg::ST_REJECTED, 17'd0, 9'd1, 9'd0, 9'd1}},
      '{fht_pkg::OP_ADD, 16'd0, 16'd8, 1'b0, 1'b1,
        '{fht_pkg::ST_DROPPED, 17'd0, 9'd1, 9'd0, 9'd1}},
      '{fht_pkg::OP_ABANDON, 16'hffff, 16'hffff, 1'b1, 1'b1,
        '{fht_pkg::ST_CLEARED, 17'd0, 9'd1, 9'd0, 9'd0}},
      '{fht_pkg::OP_ADD, 16'd65528, 16'd65535, 1'b1, 1'b1,
        '{fht_pkg::ST_ACCEPTED, 17'd131063, 9'd1, 9'd1, 9'd0}},
      '{fht_pkg::OP_ADD, 16'd0, 16'd8, 1'b1, 1'b1,
        '{fht_pkg::ST_REJECTED, 17'd131063, 9'd1, 9'd1, 9'd2}},
      '{fht_pkg::OP_ADD, 16'd0, 16'd8, 1'b0, 1'b1,
        '{fht_pkg::ST_DROPPED, 17'd131063, 9'd1, 9'd1, 9'd1}},
      '{fht_pkg::OP_ABANDON, 16'd0, 16'd0, 1'b0, 1'b1,
        '{fht_pkg::ST_CLEARED, 17'd0, 9'd1, 9'd0, 9'd0}},
      '{fht_pkg::OP_ADD, 16'd0, 16'd0, 1'b1, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd0, 16'd0, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd8, 16'd8, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd8, 16'd8, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ABANDON, 16'd0, 16'd0, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd16, 16'd8, 1'b1, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd16, 16'd16, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ABANDON, 16'd0, 16'd0, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd16, 16'd8, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd8, 16'd16, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ABANDON, 16'd0, 16'd0, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd16, 16'd8, 1'b0, 1'b0, '0},
      '{fht_pkg::OP_ADD, 16'd0, 16'd8, 1'b1, 1'b0, '0},
      '{fht_pkg::OP_ABANDON, 16'd0, 16'd0, 1'b0, 1'b0, '0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_operation = fht_pkg::OP_ADD;
   logic [OFF_W-1:0]  req_frag_offset = '0;
   logic [LEN_W-1:0]  req_frag_length = '0;
   logic              req_is_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [TOT_W-1:0]  rsp_total_length;
   logic [HOLE_W-1:0] rsp_hole_count;
   logic [FCNT_W-1:0] rsp_fragment_count;
   logic [FCNT_W-1:0] rsp_fragments_dropped;

   // tracker state as the block should hold it
   logic [OFF_W-1:0]  frag_start [MAX_FRAGS];
   logic [LEN_W-1:0]  frag_len [MAX_FRAGS];
   logic [TOT_W-1:0]  dgram_total = '0;
   logic [HOLE_W-1:0] open_gaps = 9'd1;
   logic [FCNT_W-1:0] frag_stored = '0;
   logic              dgram_bad = 1'b0;

   frag_result_type expected_results [$];
   int              fail_count = 0;
   int              items_sent = 0;
   int              burst_left = 4;

   fragment_hole_tracker_top #(.MAX_FRAGS(MAX_FRAGS)) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_frag_offset       (req_frag_offset),
      .req_frag_length       (req_frag_length),
      .req_is_last           (req_is_last),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_total_length      (rsp_total_length),
      .rsp_hole_count        (rsp_hole_count),
      .rsp_fragment_count    (rsp_fragment_count),
      .rsp_fragments_dropped (rsp_fragments_dropped)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_tracker();
      dgram_total = '0;
      open_gaps   = 9'd1;
      frag_stored = '0;
      dgram_bad   = 1'b0;
   endfunction

   function automatic bit insert_fragment(input logic [OFF_W-1:0] off,
                                          input logic [LEN_W-1:0] len,
                                          input logic last);
      int unsigned frag_end;
      int unsigned new_total;
      int unsigned pos;
      int unsigned prev_end;
      int unsigned i;
      bit          touch_prev;
      bit          touch_next;
      frag_end   = off + len;
      new_total  = dgram_total;
      pos        = 0;
      prev_end   = 0;
      touch_next = 1'b0;
      if (!last && len[2:0] != 3'd0) return 1'b0;
      if (dgram_total != 0 && frag_end > dgram_total) return 1'b0;
      if (last) begin
         if (dgram_total != 0) return 1'b0;
         new_total  = frag_end;
         touch_next = 1'b1;
      end
      while (pos < frag_stored && frag_start[pos] <= off) pos++;
      if (pos > 0) prev_end = frag_start[pos-1] + frag_len[pos-1];
      if (prev_end > off) return 1'b0;
      touch_prev = (prev_end == off);
      if (pos < frag_stored) begin
         if (last) return 1'b0;
         if (frag_end > frag_start[pos]) return 1'b0;
         if (frag_end == frag_start[pos]) touch_next = 1'b1;
      end
      if (len != 0) begin
         if (frag_stored >= MAX_FRAGS) return 1'b0;
         for (i = frag_stored; i > pos; i--) begin
            frag_start[i] = frag_start[i-1];
            frag_len[i]   = frag_len[i-1];
         end
         frag_start[pos] = off;
         frag_len[pos]   = len;
         frag_stored++;
         if (touch_prev && touch_next) open_gaps--;
         else if (!touch_prev && !touch_next) open_gaps++;
      end else if (last && touch_prev) begin
         open_gaps--;
      end
      dgram_total = new_total[TOT_W-1:0];
      return 1'b1;
   endfunction

   function automatic frag_result_type predict_result(input logic op,
                                                      input logic [OFF_W-1:0] off,
                                                      input logic [LEN_W-1:0] len,
                                                      input logic last);
      frag_result_type r;
      if (op == fht_pkg::OP_ABANDON) begin
         clear_tracker();
         r = '{fht_pkg::ST_CLEARED, dgram_total, open_gaps, frag_stored, 9'd0};
      end else if (dgram_bad) begin
         r = '{fht_pkg::ST_DROPPED, dgram_total, open_gaps, frag_stored, 9'd1};
      end else if (!insert_fragment(off, len, last)) begin
         dgram_bad = 1'b1;
         r = '{fht_pkg::ST_REJECTED, dgram_total, open_gaps, frag_stored,
               frag_stored + 9'd1};
      end else if (open_gaps == 0) begin
         r = '{fht_pkg::ST_COMPLETE, dgram_total, 9'd0, frag_stored, 9'd0};
         clear_tracker();
      end else begin
         r = '{fht_pkg::ST_ACCEPTED, dgram_total, open_gaps, frag_stored, 9'd0};
      end
      return r;
   endfunction

   task automatic send_item(input logic op, input logic [OFF_W-1:0] off,
                            input logic [LEN_W-1:0] len, input logic last,
                            input logic typed, input frag_result_type typed_result);
      frag_result_type predicted;
      req_operation   <= op;
      req_frag_offset <= off;
      req_frag_length <= len;
      req_is_last     <= last;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_result(op, off, len, last);
      expected_results.push_back(typed ? typed_result : predicted);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 6);
      end
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      burst_left = $urandom_range(1, 6);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      int               n;
      int               k;
      int               j;
      int unsigned      cum;
      int unsigned      flen;
      bit               big;
      bit               paused;
      logic [OFF_W-1:0] offs [$];
      logic [LEN_W-1:0] lens [$];
      logic             lasts [$];
      logic [OFF_W-1:0] t_off;
      logic [LEN_W-1:0] t_len;
      logic             t_last;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIR_ROWS; k++) begin
         send_item(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].off, DIRECTED_ROWS[k].len,
                   DIRECTED_ROWS[k].last, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].exp);
      end
      wait_all_results();

      // random datagrams: shuffled well-formed fragment sets, some broken
      while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
         if (!paused && items_sent >= DRAIN_AT) begin
            wait_all_results();
            paused = 1'b1;
         end
         n   = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
         big = ($urandom_range(0, 3) == 0);
         offs.delete();
         lens.delete();
         lasts.delete();
         cum = 0;
         for (k = 0; k < n - 1; k++) begin
            if ($urandom_range(0, 15) == 0) flen = 0;
            else flen = big ? 8 * $urandom_range(1, 8191 / n) : 8 * $urandom_range(1, 4);
            offs.push_back(OFF_W'(cum));
            lens.push_back(LEN_W'(flen));
            lasts.push_back(1'b0);
            cum += flen;
         end
         offs.push_back(OFF_W'(cum));
         lens.push_back(LEN_W'(big ? $urandom_range(0, 65535) : $urandom_range(0, 40)));
         lasts.push_back(1'b1);
         for (k = offs.size() - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t_off = offs[k];  offs[k]  = offs[j];  offs[j]  = t_off;
            t_len = lens[k];  lens[k]  = lens[j];  lens[j]  = t_len;
            t_last = lasts[k]; lasts[k] = lasts[j]; lasts[j] = t_last;
         end
         k = $urandom_range(0, offs.size() - 1);
         case ($urandom_range(0, 7))
            0: begin
               offs.delete(k);
               lens.delete(k);
               lasts.delete(k);
            end
            1: begin
               j = $urandom_range(0, offs.size());
               t_off = offs[k];
               t_len = lens[k];
               t_last = lasts[k];
               offs.insert(j, t_off);
               lens.insert(j, t_len);
               lasts.insert(j, t_last);
            end
            2: lens[k] = lens[k] | 16'd1;
            3: begin
               offs.insert(k, 16'($urandom_range(0, 65528)));
               lens.insert(k, 16'($urandom_range(0, 65535)));
               lasts.insert(k, 1'($urandom_range(0, 1)));
            end
            default: ;
         endcase
         for (k = 0; k < offs.size(); k++) begin
            send_item(fht_pkg::OP_ADD, offs[k], lens[k], lasts[k], 1'b0, '0);
         end
         if ((frag_stored != 0 || dgram_bad || dgram_total != 0 || open_gaps != 9'd1)
             ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 9) == 0)) begin
            send_item(fht_pkg::OP_ABANDON, 16'($urandom_range(0, 65528)), 16'($urandom),
                      1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_fragment_hole_tracker_top passed");
      end else begin
         $display("tb_fragment_hole_tracker_top failed");
      end
      $finish;
   end

   // receiver: changing stall patterns plus one long hold-off
   initial begin
      int unsigned cyc;
      int unsigned mode;
      cyc  = 0;
      mode = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 48 == 0) mode = $urandom_range(0, 3);
         if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (cyc % 3 == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      frag_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected item on result channel, status %0d", rsp_status);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("total_length", want.total_length, rsp_total_length);
            check_field("hole_count", want.hole_count, rsp_hole_count);
            check_field("fragment_count", want.fragment_count, rsp_fragment_count);
            check_field("fragments_dropped", want.fragments_dropped,
                        rsp_fragments_dropped);
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_fragment_hole_tracker_top failed");
      $finish;
   end

endmodule

>>> filelist.f
hdl/fht_pkg.sv
hdl/fht_ctrl.sv
hdl/fht_datapath.sv
hdl/fragment_hole_tracker_top.sv
dv/tb_fragment_hole_tracker_top.sv
